FILE: sv/hpmc_pkg.sv
// shared types and constants of the half-pel motion compensation row unit
// no dependencies; used by the interfaces, the lane, the merge stage and the top level
`default_nettype none

package hpmc_pkg;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned NUM_LANES = 16;
  localparam int unsigned HALF_LANES = NUM_LANES / 2;
  localparam int unsigned ROW_PIX   = NUM_LANES + 1;
  localparam int unsigned WORD_W    = HALF_LANES * PIX_W;
  localparam int unsigned OPCODE_W  = 4;

  // opcode bit positions
  localparam int unsigned OP_AVG_BIT    = 3;
  localparam int unsigned OP_NARROW_BIT = 2;

  typedef logic [PIX_W-1:0] pix_t;

  typedef enum logic [1:0] {
    MODE_COPY = 2'd0,
    MODE_X    = 2'd1,
    MODE_Y    = 2'd2,
    MODE_XY   = 2'd3
  } mode_t;

  // per-row control shared by all lanes
  typedef struct packed {
    mode_t mode;
    logic  avg_en;
    logic  narrow;
    logic  cur_par;
  } lane_ctl_t;

  // one result beat
  typedef struct packed {
    logic [WORD_W-1:0] pred_lo;
    logic [WORD_W-1:0] pred_hi;
    logic              last_out;
  } out_beat_t;

endpackage

`default_nettype wire

FILE: sv/hpmc_if.sv
// valid/ready channel interfaces for the input rows and the predicted rows
// depends on hpmc_pkg
`default_nettype none

interface hpmc_in_if;
  logic                          valid;
  logic                          ready;
  logic [hpmc_pkg::OPCODE_W-1:0] opcode;
  logic                          start_block;
  logic                          last_row;
  logic [hpmc_pkg::WORD_W-1:0]   ref_lo;
  logic [hpmc_pkg::WORD_W-1:0]   ref_hi;
  logic [hpmc_pkg::PIX_W-1:0]    ref_tail;
  logic [hpmc_pkg::WORD_W-1:0]   dest_lo;
  logic [hpmc_pkg::WORD_W-1:0]   dest_hi;

  modport source (
    output valid, opcode, start_block, last_row, ref_lo, ref_hi, ref_tail,
           dest_lo, dest_hi,
    input  ready
  );
  modport sink (
    input  valid, opcode, start_block, last_row, ref_lo, ref_hi, ref_tail,
           dest_lo, dest_hi,
    output ready
  );
endinterface

interface hpmc_out_if;
  logic                        valid;
  logic                        ready;
  logic [hpmc_pkg::WORD_W-1:0] pred_lo;
  logic [hpmc_pkg::WORD_W-1:0] pred_hi;
  logic                        last_out;

  modport source (
    output valid, pred_lo, pred_hi, last_out,
    input  ready
  );
  modport sink (
    input  valid, pred_lo, pred_hi, last_out,
    output ready
  );
endinterface

`default_nettype wire

FILE: sv/hpmc_lane.sv
// one pixel lane: copy, horizontal, vertical or diagonal half-pel, then optional dest average
// depends on hpmc_pkg
`default_nettype none

module hpmc_lane (
  input  hpmc_pkg::lane_ctl_t ctl,
  input  hpmc_pkg::pix_t      cur0,
  input  hpmc_pkg::pix_t      cur1,
  input  hpmc_pkg::pix_t      prv0,
  input  hpmc_pkg::pix_t      prv1,
  input  hpmc_pkg::pix_t      dst,
  output hpmc_pkg::pix_t      px
);

  function automatic hpmc_pkg::pix_t mean8(input hpmc_pkg::pix_t a, input hpmc_pkg::pix_t b);
    logic [hpmc_pkg::PIX_W:0] s;
    s = {1'b0, a} + {1'b0, b} + {{hpmc_pkg::PIX_W{1'b0}}, 1'b1};
    return s[hpmc_pkg::PIX_W:1];
  endfunction

  function automatic hpmc_pkg::pix_t dec_sat(input hpmc_pkg::pix_t a);
    return (a == '0) ? a : a - hpmc_pkg::pix_t'(1);
  endfunction

  hpmc_pkg::pix_t m_pc0, m_pc1, h_cur, h_prv, v;

  always_comb begin
    m_pc0 = mean8(prv0, cur0);
    m_pc1 = mean8(prv1, cur1);
    h_cur = mean8(cur0, cur1);
    h_prv = mean8(prv0, prv1);
    unique case (ctl.mode)
      hpmc_pkg::MODE_COPY: v = cur0;
      hpmc_pkg::MODE_X:    v = h_cur;
      hpmc_pkg::MODE_Y:    v = m_pc0;
      hpmc_pkg::MODE_XY: begin
        if (ctl.avg_en && ctl.narrow) begin
          // column-wise form for 8-wide average
          v = mean8(dec_sat(m_pc0), m_pc1);
        end else if (ctl.cur_par) begin
          v = mean8(h_prv, dec_sat(h_cur));
        end else begin
          v = mean8(dec_sat(h_prv), h_cur);
        end
      end
      default: v = cur0;
    endcase
    px = ctl.avg_en ? mean8(v, dst) : v;
  end

endmodule

`default_nettype wire

FILE: sv/hpmc_merge.sv
// merge stage: packs the lane bytes into a result beat and holds it in an output register with skid
// depends on hpmc_pkg
`default_nettype none

module hpmc_merge (
  input  logic                clk,
  input  logic                rst_n,
  input  hpmc_pkg::pix_t      lane_px [hpmc_pkg::NUM_LANES],
  input  logic                narrow,
  input  logic                last_row,
  input  logic                produce,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output hpmc_pkg::out_beat_t out_beat
);

  hpmc_pkg::out_beat_t new_beat;
  hpmc_pkg::out_beat_t out_r, skid_r;
  logic                out_v_r, skid_v_r;
  logic                out_free;

  always_comb begin
    new_beat = '0;
    for (int i = 0; i < hpmc_pkg::HALF_LANES; i++) begin
      new_beat.pred_lo[i*hpmc_pkg::PIX_W +: hpmc_pkg::PIX_W] = lane_px[i];
      // upper half is zero at width 8
      new_beat.pred_hi[i*hpmc_pkg::PIX_W +: hpmc_pkg::PIX_W] =
        narrow ? '0 : lane_px[i + hpmc_pkg::HALF_LANES];
    end
    new_beat.last_out = last_row;
  end

  assign out_free  = !out_v_r || out_ready;
  assign in_ready  = !skid_v_r;
  assign out_valid = out_v_r;
  assign out_beat  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_free) begin
      if (skid_v_r) begin
        out_r    <= skid_r;
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_r   <= new_beat;
        out_v_r <= produce;
      end
    end else if (produce) begin
      skid_r   <= new_beat;
      skid_v_r <= 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: sv/halfpel_motion_comp_row_unit.sv
// half-pel motion compensation row unit: sixteen pixel lanes, previous-row state, merge stage
// depends on hpmc_pkg, hpmc_if, hpmc_lane and hpmc_merge
//
// usage
//   in_ch carries one reference row of 17 pixels plus 16 destination pixels per beat,
//   with an opcode picking put/average, width 16/8 and copy, x, y or xy half-pel.
//   out_ch carries one predicted row per beat (pred_hi zero at width 8).
//   in the y and xy modes a beat with start_block set only primes the previous-row
//   state and yields no result beat.
// timing
//   all sixteen lanes work in parallel on one beat; its result is registered in the merge
//   output register, or in the skid register while out_ch stalls, and the unit
//   takes one beat every cycle while out_ch keeps up.
// reset
//   synchronous rst_n clears the previous row to zero, the row parity to zero and the
//   output and skid valids; the unit is ready once reset is released.
// stall
//   when out_ch stalls, one more result is caught in a skid register and in_ch.ready
//   then drops until the held beat drains; no result is lost or repeated.
`default_nettype none

module halfpel_motion_comp_row_unit (
  input  logic                clk,
  input  logic                rst_n,
  hpmc_in_if.sink             in_ch,
  hpmc_out_if.source          out_ch
);

  // previous reference row and its parity within the block
  hpmc_pkg::pix_t prev_r [hpmc_pkg::ROW_PIX];
  logic           parity_r;

  hpmc_pkg::pix_t      cur [hpmc_pkg::ROW_PIX];
  hpmc_pkg::pix_t      dst [hpmc_pkg::NUM_LANES];
  hpmc_pkg::pix_t      lane_px [hpmc_pkg::NUM_LANES];
  hpmc_pkg::lane_ctl_t ctl;
  hpmc_pkg::out_beat_t out_beat;
  logic                in_acc;
  logic                primes;
  logic                produce;
  logic                in_ready;
  logic                out_valid;

  // unpack the beat into pixels
  always_comb begin
    for (int i = 0; i < hpmc_pkg::HALF_LANES; i++) begin
      cur[i] = in_ch.ref_lo[i*hpmc_pkg::PIX_W +: hpmc_pkg::PIX_W];
      cur[i + hpmc_pkg::HALF_LANES] = in_ch.ref_hi[i*hpmc_pkg::PIX_W +: hpmc_pkg::PIX_W];
      dst[i] = in_ch.dest_lo[i*hpmc_pkg::PIX_W +: hpmc_pkg::PIX_W];
      dst[i + hpmc_pkg::HALF_LANES] = in_ch.dest_hi[i*hpmc_pkg::PIX_W +: hpmc_pkg::PIX_W];
    end
    cur[hpmc_pkg::NUM_LANES] = in_ch.ref_tail;
  end

  // row control shared by the lanes
  always_comb begin
    ctl.mode    = hpmc_pkg::mode_t'(in_ch.opcode[1:0]);
    ctl.avg_en  = in_ch.opcode[hpmc_pkg::OP_AVG_BIT];
    ctl.narrow  = in_ch.opcode[hpmc_pkg::OP_NARROW_BIT];
    // a block start is row 0, otherwise the parity flips
    ctl.cur_par = in_ch.start_block ? 1'b0 : !parity_r;
  end

  assign in_acc  = in_ch.valid && in_ready;
  // vertical modes use the first row of a block only as state
  assign primes  = in_ch.start_block &&
                   (ctl.mode == hpmc_pkg::MODE_Y || ctl.mode == hpmc_pkg::MODE_XY);
  assign produce = in_acc && !primes;

  for (genvar g = 0; g < hpmc_pkg::NUM_LANES; g++) begin : g_lane
    hpmc_lane u_lane (
      .ctl  (ctl),
      .cur0 (cur[g]),
      .cur1 (cur[g+1]),
      .prv0 (prev_r[g]),
      .prv1 (prev_r[g+1]),
      .dst  (dst[g]),
      .px   (lane_px[g])
    );
  end

  // every taken beat, in every mode, becomes the previous row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < hpmc_pkg::ROW_PIX; i++) begin
        prev_r[i] <= '0;
      end
      parity_r <= 1'b0;
    end else if (in_acc) begin
      for (int i = 0; i < hpmc_pkg::ROW_PIX; i++) begin
        prev_r[i] <= cur[i];
      end
      parity_r <= ctl.cur_par;
    end
  end

  hpmc_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .lane_px   (lane_px),
    .narrow    (ctl.narrow),
    .last_row  (in_ch.last_row),
    .produce   (produce),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_beat  (out_beat)
  );

  assign in_ch.ready     = in_ready;
  assign out_ch.valid    = out_valid;
  assign out_ch.pred_lo  = out_beat.pred_lo;
  assign out_ch.pred_hi  = out_beat.pred_hi;
  assign out_ch.last_out = out_beat.last_out;

  // input back-pressure only while a result is held on the output
  a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid)
    else $error("input stalled with no result held");

  // a block start always restarts the row parity
  a_start_clears_parity: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.start_block) |=> !parity_r)
    else $error("row parity not cleared at block start");

  // the previous row follows each taken beat
  a_prev_row_capture: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (prev_r[0] == $past(in_ch.ref_lo[7:0]) &&
                prev_r[hpmc_pkg::NUM_LANES] == $past(in_ch.ref_tail)))
    else $error("previous row not captured");

  // a priming row never produces a result beat
  a_prime_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && primes && !out_ch.valid) |=> !out_ch.valid)
    else $error("priming row produced a result");

endmodule

`default_nettype wire

FILE: dv/tb_halfpel_motion_comp_row_unit.sv
// self-checking testbench for the half-pel motion compensation row unit
// depends on hpmc_pkg, hpmc_if and the rtl of halfpel_motion_comp_row_unit

module tb_halfpel_motion_comp_row_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // generous bound: ~1200 beats at a slow sink and long sender gaps, plus the long hold-off
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_CAP  = 200;
  localparam int HOLD_AFTER  = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int ROW_TARGET  = 1150;

  typedef logic [hpmc_pkg::OPCODE_W-1:0] opcode_t;

  // one input beat as the sender sees it
  typedef struct packed {
    opcode_t                       opcode;
    logic                          start_block;
    logic                          last_row;
    logic [hpmc_pkg::WORD_W-1:0]   ref_lo;
    logic [hpmc_pkg::WORD_W-1:0]   ref_hi;
    hpmc_pkg::pix_t                ref_tail;
    logic [hpmc_pkg::WORD_W-1:0]   dest_lo;
    logic [hpmc_pkg::WORD_W-1:0]   dest_hi;
  } ref_row_t;

  typedef enum int {FILL_RANDOM, FILL_EDGE} fill_t;
  typedef enum int {SINK_OPEN, SINK_COIN, SINK_SLOW, SINK_TOGGLE} sink_kind_t;

  logic clk;
  logic rst_n;

  hpmc_in_if  in_ch ();
  hpmc_out_if out_ch ();

  halfpel_motion_comp_row_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // stimulus and scoreboard storage
  ref_row_t            ref_rows_todo[$];
  hpmc_pkg::out_beat_t pred_rows_due[$];

  // predictor state: the row above and whether it sat on an odd row of its block
  hpmc_pkg::pix_t above_row [hpmc_pkg::ROW_PIX];
  logic           above_odd;

  int   rows_total;
  int   rows_taken;
  int   rows_checked;
  int   mismatch_cnt;
  int   cycle_cnt;
  logic in_taken;

  // sender burst state
  int       burst_left;
  int       gap_left;
  ref_row_t next_row;

  // receiver stall state
  sink_kind_t sink_kind;
  int         sink_left;
  int         hold_left;
  logic       hold_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic hpmc_pkg::pix_t rounded_mean(input hpmc_pkg::pix_t a,
                                                  input hpmc_pkg::pix_t b);
    logic [hpmc_pkg::PIX_W:0] sum;
    sum = {1'b0, a} + {1'b0, b} + 9'd1;
    return sum[hpmc_pkg::PIX_W:1];
  endfunction

  function automatic hpmc_pkg::pix_t minus_one_sat(input hpmc_pkg::pix_t a);
    return (a == '0) ? '0 : a - 8'd1;
  endfunction

  function automatic hpmc_pkg::pix_t pick_pix(input fill_t flavour);
    if (flavour == FILL_RANDOM) begin
      return hpmc_pkg::pix_t'($urandom_range(0, 255));
    end
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'h01;
      2: return 8'hfe;
      default: return 8'hff;
    endcase
  endfunction

  function automatic logic [hpmc_pkg::WORD_W-1:0] pick_word(input fill_t flavour);
    logic [hpmc_pkg::WORD_W-1:0] w;
    for (int i = 0; i < hpmc_pkg::HALF_LANES; i++) begin
      w[hpmc_pkg::PIX_W*i +: hpmc_pkg::PIX_W] = pick_pix(flavour);
    end
    return w;
  endfunction

  function automatic ref_row_t make_row(input opcode_t op, input logic start,
                                        input logic last, input fill_t flavour);
    ref_row_t r;
    r.opcode      = op;
    r.start_block = start;
    r.last_row    = last;
    r.ref_lo      = pick_word(flavour);
    r.ref_hi      = pick_word(flavour);
    r.ref_tail    = pick_pix(flavour);
    r.dest_lo     = pick_word(flavour);
    r.dest_hi     = pick_word(flavour);
    return r;
  endfunction

  // works out the predicted row for one taken beat and advances the row state
  task automatic compute_halfpel_row(input ref_row_t r);
    hpmc_pkg::pix_t      cur [hpmc_pkg::ROW_PIX];
    hpmc_pkg::pix_t      dst [hpmc_pkg::NUM_LANES];
    hpmc_pkg::pix_t      p   [hpmc_pkg::NUM_LANES];
    hpmc_pkg::pix_t      a, b, v;
    hpmc_pkg::mode_t     md;
    logic                avg_en, narrow, odd_n;
    int                  n;
    hpmc_pkg::out_beat_t beat;
    md     = hpmc_pkg::mode_t'(r.opcode[1:0]);
    avg_en = r.opcode[hpmc_pkg::OP_AVG_BIT];
    narrow = r.opcode[hpmc_pkg::OP_NARROW_BIT];
    for (int i = 0; i < hpmc_pkg::HALF_LANES; i++) begin
      cur[i]                       = r.ref_lo[hpmc_pkg::PIX_W*i +: hpmc_pkg::PIX_W];
      cur[i+hpmc_pkg::HALF_LANES]  = r.ref_hi[hpmc_pkg::PIX_W*i +: hpmc_pkg::PIX_W];
      dst[i]                       = r.dest_lo[hpmc_pkg::PIX_W*i +: hpmc_pkg::PIX_W];
      dst[i+hpmc_pkg::HALF_LANES]  = r.dest_hi[hpmc_pkg::PIX_W*i +: hpmc_pkg::PIX_W];
    end
    cur[hpmc_pkg::NUM_LANES] = r.ref_tail;
    odd_n = r.start_block ? 1'b0 : ~above_odd;

    // first row of a vertical block only primes the row state
    if ((md == hpmc_pkg::MODE_Y || md == hpmc_pkg::MODE_XY) && r.start_block) begin
      above_row = cur;
      above_odd = 1'b0;
      return;
    end

    n = narrow ? hpmc_pkg::HALF_LANES : hpmc_pkg::NUM_LANES;
    for (int i = 0; i < hpmc_pkg::NUM_LANES; i++) begin
      p[i] = '0;
    end
    for (int i = 0; i < n; i++) begin
      case (md)
        hpmc_pkg::MODE_COPY: v = cur[i];
        hpmc_pkg::MODE_X:    v = rounded_mean(cur[i], cur[i+1]);
        hpmc_pkg::MODE_Y:    v = rounded_mean(above_row[i], cur[i]);
        default: begin
          if (avg_en && narrow) begin
            // column-wise approximation of the narrow average form
            a = minus_one_sat(rounded_mean(above_row[i], cur[i]));
            b = rounded_mean(above_row[i+1], cur[i+1]);
          end else begin
            a = rounded_mean(above_row[i], above_row[i+1]);
            b = rounded_mean(cur[i], cur[i+1]);
            if (odd_n) b = minus_one_sat(b);
            else       a = minus_one_sat(a);
          end
          v = rounded_mean(a, b);
        end
      endcase
      if (avg_en) v = rounded_mean(v, dst[i]);
      p[i] = v;
    end
    above_row = cur;
    above_odd = odd_n;

    for (int i = 0; i < hpmc_pkg::HALF_LANES; i++) begin
      beat.pred_lo[hpmc_pkg::PIX_W*i +: hpmc_pkg::PIX_W] = p[i];
      beat.pred_hi[hpmc_pkg::PIX_W*i +: hpmc_pkg::PIX_W] = p[i+hpmc_pkg::HALF_LANES];
    end
    beat.last_out = r.last_row;
    pred_rows_due.push_back(beat);
  endtask

  // sender: bursts of random length with random gaps, changes at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (gap_left > 0 || ref_rows_todo.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_ch.valid <= 1'b0;
      end else begin
        next_row = ref_rows_todo.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.opcode      <= next_row.opcode;
        in_ch.start_block <= next_row.start_block;
        in_ch.last_row    <= next_row.last_row;
        in_ch.ref_lo      <= next_row.ref_lo;
        in_ch.ref_hi      <= next_row.ref_hi;
        in_ch.ref_tail    <= next_row.ref_tail;
        in_ch.dest_lo     <= next_row.dest_lo;
        in_ch.dest_hi     <= next_row.dest_hi;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          // a third of the bursts run straight into the next one
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // receiver: stall pattern of its own, plus one long hold-off so the skid fills
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (!hold_done && rows_checked >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      if (sink_left == 0) begin
        sink_kind = sink_kind_t'($urandom_range(0, 3));
        sink_left = $urandom_range(5, 60);
      end
      sink_left--;
      case (sink_kind)
        SINK_OPEN:   out_ch.ready <= 1'b1;
        SINK_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
        SINK_SLOW:   out_ch.ready <= ($urandom_range(0, 3) == 0);
        default:     out_ch.ready <= ~out_ch.ready;
      endcase
    end
  end

  // monitor: checks result beats first, then predicts from the input beat taken at this edge
  always @(posedge clk) begin
    hpmc_pkg::out_beat_t want;
    ref_row_t            seen;
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      rows_checked++;
      if (pred_rows_due.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_CAP) begin
          $display("%0t: unexpected row beat exp none got lo %h hi %h last %b", $time,
                   out_ch.pred_lo, out_ch.pred_hi, out_ch.last_out);
        end
      end else begin
        want = pred_rows_due.pop_front();
        if (want.pred_lo !== out_ch.pred_lo || want.pred_hi !== out_ch.pred_hi ||
            want.last_out !== out_ch.last_out) begin
          mismatch_cnt++;
          // cap the log so a badly broken unit still gives a readable run
          if (mismatch_cnt <= REPORT_CAP) begin
            $display("%0t: row %0d mismatch pred_lo exp %h got %h", $time, rows_checked,
                     want.pred_lo, out_ch.pred_lo);
            $display("%0t: row %0d mismatch pred_hi exp %h got %h", $time, rows_checked,
                     want.pred_hi, out_ch.pred_hi);
            $display("%0t: row %0d mismatch last_out exp %b got %b", $time, rows_checked,
                     want.last_out, out_ch.last_out);
          end
        end
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      seen.opcode      = in_ch.opcode;
      seen.start_block = in_ch.start_block;
      seen.last_row    = in_ch.last_row;
      seen.ref_lo      = in_ch.ref_lo;
      seen.ref_hi      = in_ch.ref_hi;
      seen.ref_tail    = in_ch.ref_tail;
      seen.dest_lo     = in_ch.dest_lo;
      seen.dest_hi     = in_ch.dest_hi;
      compute_halfpel_row(seen);
      rows_taken++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    ref_row_t r;
    int       rows;
    opcode_t  op;
    fill_t    flavour;

    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.opcode = '0;
    in_ch.start_block = 1'b0;
    in_ch.last_row    = 1'b0;
    in_ch.ref_lo   = '0;
    in_ch.ref_hi   = '0;
    in_ch.ref_tail = '0;
    in_ch.dest_lo  = '0;
    in_ch.dest_hi  = '0;
    out_ch.ready   = 1'b0;
    in_taken     = 1'b0;
    rows_taken   = 0;
    rows_checked = 0;
    mismatch_cnt = 0;
    cycle_cnt    = 0;
    burst_left   = 0;
    gap_left     = 0;
    sink_kind    = SINK_OPEN;
    sink_left    = 0;
    hold_left    = 0;
    hold_done    = 1'b0;
    above_odd    = 1'b0;
    for (int i = 0; i < hpmc_pkg::ROW_PIX; i++) above_row[i] = '0;

    // vertical continuation straight after reset runs against a zero row
    r = make_row({1'b0, 1'b0, hpmc_pkg::MODE_Y}, 1'b0, 1'b0, FILL_EDGE);
    r.ref_lo = '1; r.ref_hi = '1; r.ref_tail = '1;
    ref_rows_todo.push_back(r);
    r = make_row({1'b0, 1'b0, hpmc_pkg::MODE_XY}, 1'b0, 1'b0, FILL_EDGE);
    ref_rows_todo.push_back(r);
    // priming row flagged as last as well: still no beat out
    ref_rows_todo.push_back(make_row({1'b1, 1'b0, hpmc_pkg::MODE_Y}, 1'b1, 1'b1, FILL_EDGE));
    // all-zero diagonal block: the minus one saturates on both row parities
    r = make_row({1'b0, 1'b0, hpmc_pkg::MODE_XY}, 1'b1, 1'b0, FILL_EDGE);
    r.ref_lo = '0; r.ref_hi = '0; r.ref_tail = '0;
    ref_rows_todo.push_back(r);
    r.start_block = 1'b0;
    ref_rows_todo.push_back(r);
    r.last_row = 1'b1;
    ref_rows_todo.push_back(r);
    // block start under copy mode gives a beat and resets the parity
    ref_rows_todo.push_back(make_row({1'b0, 1'b0, hpmc_pkg::MODE_COPY}, 1'b1, 1'b0,
                                     FILL_EDGE));
    // horizontal at width 16 with the tail pixel at both extremes
    r = make_row({1'b0, 1'b0, hpmc_pkg::MODE_X}, 1'b0, 1'b0, FILL_EDGE);
    r.ref_lo = '1; r.ref_hi = '1; r.ref_tail = '0;
    ref_rows_todo.push_back(r);
    r.ref_lo = '0; r.ref_hi = '0; r.ref_tail = '1;
    ref_rows_todo.push_back(r);
    // horizontal at width 8: pixel 8 feeds the last lane, dest_hi ignored
    r = make_row({1'b0, 1'b1, hpmc_pkg::MODE_X}, 1'b0, 1'b1, FILL_EDGE);
    r.ref_lo = '0; r.ref_hi = '1;
    ref_rows_todo.push_back(r);
    // every opcode once, continuing whatever row came before
    for (int k = 0; k < 16; k++) begin
      r = make_row(k[hpmc_pkg::OPCODE_W-1:0], 1'b0, k[0], FILL_EDGE);
      r.dest_lo = k[1] ? '1 : '0;
      r.dest_hi = k[1] ? '0 : '1;
      ref_rows_todo.push_back(r);
    end

    // random part: mostly well-formed blocks, some noise and broken blocks
    while (ref_rows_todo.size() < ROW_TARGET + 25) begin
      flavour = ($urandom_range(0, 3) == 0) ? FILL_EDGE : FILL_RANDOM;
      if ($urandom_range(0, 9) == 0) begin
        ref_rows_todo.push_back(make_row(opcode_t'($urandom_range(0, 15)),
                                         1'($urandom_range(0, 1)),
                                         1'($urandom_range(0, 1)), flavour));
      end else begin
        op = opcode_t'($urandom_range(0, 15));
        case ($urandom_range(0, 3))
          0:       rows = 9;
          1:       rows = 17;
          default: rows = $urandom_range(1, 17);
        endcase
        for (int k = 0; k < rows; k++) begin
          r = make_row(op, k == 0, k == rows - 1, flavour);
          // now and then a block loses its start flag
          if (k == 0 && $urandom_range(0, 11) == 0) r.start_block = 1'b0;
          ref_rows_todo.push_back(r);
        end
      end
    end
    rows_total = ref_rows_todo.size();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (rows_taken != rows_total || pred_rows_due.size() != 0) @(negedge clk);
    // the wait below catches any stray beat after the scoreboard drains
    repeat (10) @(negedge clk);

    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
